// File: hw/rtl/led_pwm_fade_sequencer_core_macros.svh
// assertion helpers, all sampled on clk
`ifndef LED_PWM_FADE_SEQUENCER_CORE_MACROS_SVH
`define LED_PWM_FADE_SEQUENCER_CORE_MACROS_SVH

// checked only out of reset
`define LPFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define LPFS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/lpfs_pkg.sv
package lpfs_pkg;

    localparam int STEP_BITS     = 20;
    localparam int RESET_SPACING = 166;
    localparam int RESET_SPACED  = 3;

    localparam logic [15:0] FULL_PERIOD_RESET = 16'd1000;
    localparam logic [15:0] SWEEP_LIMIT_RESET = 16'd500;
    localparam logic [15:0] STEP_BASE_RESET   = 16'd4;

    localparam logic [1:0] REG_FULL_PERIOD = 2'd0;
    localparam logic [1:0] REG_SWEEP_LIMIT = 2'd1;
    localparam logic [1:0] REG_STEP_BASE   = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_MODE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_INCR   = 2'd1,
        MODE_DECR   = 2'd2,
        MODE_TOGGLE = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  up;
    } chan_ctl_t;

    typedef struct packed {
        logic [15:0] full_period;
        logic [15:0] sweep_limit;
        logic [15:0] step_base;
    } cfg_t;

endpackage

// File: hw/rtl/lpfs_regs.sv
module lpfs_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output lpfs_pkg::cfg_t    cfg
);

    lpfs_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_period <= lpfs_pkg::FULL_PERIOD_RESET;
            cfg_reg.sweep_limit <= lpfs_pkg::SWEEP_LIMIT_RESET;
            cfg_reg.step_base   <= lpfs_pkg::STEP_BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // writes past the last register are dropped
            unique case (cfg_index)
                lpfs_pkg::REG_FULL_PERIOD: cfg_reg.full_period <= cfg_data;
                lpfs_pkg::REG_SWEEP_LIMIT: cfg_reg.sweep_limit <= cfg_data;
                lpfs_pkg::REG_STEP_BASE:   cfg_reg.step_base   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: hw/rtl/lpfs_channel.sv
module lpfs_channel #(
    parameter int DUTY_BITS = 16
) (
    input  logic [DUTY_BITS-1:0]          duty,
    input  lpfs_pkg::chan_ctl_t           ctl,
    input  logic [lpfs_pkg::STEP_BITS-1:0] step,
    input  logic [15:0]                   sweep_limit,
    output logic [DUTY_BITS-1:0]          duty_tick,
    output lpfs_pkg::chan_ctl_t           ctl_tick,
    output logic                          active
);

    localparam int W = ((DUTY_BITS > lpfs_pkg::STEP_BITS) ? DUTY_BITS : lpfs_pkg::STEP_BITS) + 2;
    localparam logic [W-1:0] DMAX = W'((64'd1 << DUTY_BITS) - 64'd1);

    logic [W-1:0] d;
    logic [W-1:0] s;
    logic [W-1:0] lim;
    logic [W-1:0] t;
    logic [W-1:0] u;

    assign d   = W'(duty);
    assign s   = W'(step);
    assign lim = W'(sweep_limit);

    always_comb
    begin
        t = d;
        u = d;
        ctl_tick = ctl;
        active = 1'b1;
        unique case (ctl.mode)
            lpfs_pkg::MODE_MANUAL:
            begin
                active = 1'b0;
            end
            lpfs_pkg::MODE_INCR:
            begin
                u = d + s;
                t = (u > lim) ? u - lim : u;
            end
            lpfs_pkg::MODE_DECR:
            begin
                u = (d < s) ? d + lim : d;
                t = (u < s) ? '0 : u - s;
            end
            lpfs_pkg::MODE_TOGGLE:
            begin
                if (ctl.up)
                begin
                    if (d > lim)
                    begin
                        t = lim;
                        ctl_tick.up = 1'b0;
                    end
                    else
                    begin
                        t = d + s;
                    end
                end
                else
                begin
                    if (d < s)
                    begin
                        t = '0;
                        ctl_tick.up = 1'b1;
                    end
                    else
                    begin
                        t = d - s;
                    end
                end
            end
            default: ;
        endcase
    end

    // saturate to the duty range
    assign duty_tick = (t > DMAX) ? DMAX[DUTY_BITS-1:0] : t[DUTY_BITS-1:0];

endmodule

// File: hw/rtl/led_pwm_fade_sequencer_core.sv
// Four-output LED fade sequencer: each beat on the input channel (tick, set duty, advance mode)
// is taken into an input register and, once the result register can advance, updates the
// channels' duty, mode and sweep direction (a tick every channel, a set or mode beat only the
// addressed one) in one pass of per-channel adders and comparators, loading the result
// register with all duties and the changed flag. One beat is accepted every cycle unless the
// result side stalls, and a stalled result holds the input register until it is taken.
// Configuration writes are always accepted and act on the next beat reaching the update stage.
module led_pwm_fade_sequencer_core #(
    parameter int CHANNELS  = 4,
    parameter int DUTY_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [1:0]  channel,
    input  logic [15:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] duty_zero,
    output logic [15:0] duty_one,
    output logic [15:0] duty_two,
    output logic [15:0] duty_three,
    output logic        changed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

`include "led_pwm_fade_sequencer_core_macros.svh"

    localparam int XW = DUTY_BITS + 16;
    localparam logic [63:0] DMAX64 = (64'd1 << DUTY_BITS) - 64'd1;

    lpfs_pkg::cfg_t cfg;

    logic        s1_valid_reg;
    logic [1:0]  s1_cmd_reg;
    logic [1:0]  s1_ch_reg;
    logic [15:0] s1_value_reg;

    logic        out_valid_reg;
    logic [15:0] out_duty_reg [4];
    logic        changed_reg;

    logic [DUTY_BITS-1:0] duty_reg  [CHANNELS];
    logic [DUTY_BITS-1:0] duty_next [CHANNELS];
    logic [DUTY_BITS-1:0] duty_tick [CHANNELS];
    lpfs_pkg::chan_ctl_t  ctl_reg   [CHANNELS];
    lpfs_pkg::chan_ctl_t  ctl_next  [CHANNELS];
    lpfs_pkg::chan_ctl_t  ctl_tick  [CHANNELS];
    logic [CHANNELS-1:0]  active;
    logic [CHANNELS-1:0]  hit;
    logic [lpfs_pkg::STEP_BITS-1:0] step [CHANNELS];

    logic [15:0]          set_clamped;
    logic [DUTY_BITS-1:0] set_duty;
    logic [15:0]          out_next [4];
    logic                 changed_next;
    logic                 advance;
    logic                 fire;
    logic                 accept;

    lpfs_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // set value clamped to the period, then to the duty range
    assign set_clamped = (s1_value_reg > cfg.full_period) ? cfg.full_period : s1_value_reg;
    assign set_duty = (64'(set_clamped) > DMAX64) ? DMAX64[DUTY_BITS-1:0]
                                                  : DUTY_BITS'(set_clamped);

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        localparam logic [63:0] RST_RAW = (c < lpfs_pkg::RESET_SPACED)
            ? 64'(c) * 64'(lpfs_pkg::RESET_SPACING) : 64'd0;
        localparam logic [63:0] RST_SAT = (RST_RAW > DMAX64) ? DMAX64 : RST_RAW;

        assign step[c] = lpfs_pkg::STEP_BITS'(cfg.step_base)
                       * lpfs_pkg::STEP_BITS'(c + 1);
        assign hit[c]  = (32'(s1_ch_reg) == 32'(c));

        lpfs_channel #(
            .DUTY_BITS (DUTY_BITS)
        ) u_chan (
            .duty        (duty_reg[c]),
            .ctl         (ctl_reg[c]),
            .step        (step[c]),
            .sweep_limit (cfg.sweep_limit),
            .duty_tick   (duty_tick[c]),
            .ctl_tick    (ctl_tick[c]),
            .active      (active[c])
        );

        always_comb
        begin
            duty_next[c] = duty_reg[c];
            ctl_next[c]  = ctl_reg[c];
            case (s1_cmd_reg)
                lpfs_pkg::CMD_TICK:
                begin
                    duty_next[c] = duty_tick[c];
                    ctl_next[c]  = ctl_tick[c];
                end
                lpfs_pkg::CMD_SET:
                begin
                    if (hit[c])
                    begin
                        duty_next[c]     = set_duty;
                        ctl_next[c].mode = lpfs_pkg::MODE_MANUAL;
                    end
                end
                lpfs_pkg::CMD_MODE:
                begin
                    if (hit[c])
                    begin
                        ctl_next[c].mode = lpfs_pkg::mode_t'(2'(ctl_reg[c].mode) + 2'd1);
                    end
                end
                default: ;
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                duty_reg[c]    <= RST_SAT[DUTY_BITS-1:0];
                ctl_reg[c].mode <= lpfs_pkg::MODE_TOGGLE;
                ctl_reg[c].up   <= 1'b1;
            end
            else if (fire)
            begin
                duty_reg[c] <= duty_next[c];
                ctl_reg[c]  <= ctl_next[c];
            end
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_out
        if (k < CHANNELS)
        begin : g_live
            logic [XW-1:0] ext;
            assign ext = XW'(duty_next[k]);
            assign out_next[k] = ext[15:0];
        end
        else
        begin : g_none
            assign out_next[k] = '0;
        end
    end

    always_comb
    begin
        case (s1_cmd_reg)
            lpfs_pkg::CMD_TICK: changed_next = |active;
            lpfs_pkg::CMD_SET:  changed_next = |hit;
            default:            changed_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= command;
            s1_ch_reg    <= channel;
            s1_value_reg <= value;
        end
        if (fire)
        begin
            out_duty_reg <= out_next;
            changed_reg  <= changed_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign duty_zero  = out_duty_reg[0];
    assign duty_one   = out_duty_reg[1];
    assign duty_two   = out_duty_reg[2];
    assign duty_three = out_duty_reg[3];
    assign changed    = changed_reg;

    `LPFS_ASSERT_ALWAYS(a_stall_only_full, in_stall |-> (s1_valid_reg && out_valid_reg), "input stalled with room in the pipe")
    `LPFS_ASSERT(a_fire_gives_result, fire |=> out_valid_reg, "processed beat left no result")
    `LPFS_ASSERT(a_drain_empties, (out_valid_reg && !out_stall && !s1_valid_reg) |=> !out_valid_reg, "result repeated after it was taken")
    `LPFS_ASSERT(a_set_forces_manual, (fire && s1_cmd_reg == lpfs_pkg::CMD_SET && s1_ch_reg == 2'd0) |=> (ctl_reg[0].mode == lpfs_pkg::MODE_MANUAL), "set did not force manual mode")

endmodule

// File: sim/tb_led_pwm_fade_sequencer_core.sv
module tb_led_pwm_fade_sequencer_core;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES = 6;
    localparam int BEATS_PER_PHASE = 225;

    typedef struct packed {
        logic             changed;
        logic [3:0][15:0] duty;
    } duty_frame_t;

    class duty_tracker;
        lpfs_pkg::cfg_t  regs;
        logic [15:0]     duty[4];
        lpfs_pkg::mode_t mode[4];
        logic            up[4];
        duty_frame_t     due[$];
        int              errors;
        int              beats;
        int              checked;
        string           lane_name[4] = '{"duty_zero", "duty_one", "duty_two", "duty_three"};

        function new();
            regs.full_period = lpfs_pkg::FULL_PERIOD_RESET;
            regs.sweep_limit = lpfs_pkg::SWEEP_LIMIT_RESET;
            regs.step_base   = lpfs_pkg::STEP_BASE_RESET;
            for (int c = 0; c < 4; c++)
            begin
                duty[c] = (c < lpfs_pkg::RESET_SPACED) ? 16'(c * lpfs_pkg::RESET_SPACING)
                                                       : 16'd0;
                mode[c] = lpfs_pkg::MODE_TOGGLE;
                up[c]   = 1'b1;
            end
            errors  = 0;
            beats   = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                lpfs_pkg::REG_FULL_PERIOD: regs.full_period = data;
                lpfs_pkg::REG_SWEEP_LIMIT: regs.sweep_limit = data;
                lpfs_pkg::REG_STEP_BASE:   regs.step_base   = data;
                default: ;
            endcase
        endfunction

        function void take_beat(logic [1:0] cmd, logic [1:0] ch, logic [15:0] val);
            duty_frame_t f;
            logic [31:0] d;
            logic [31:0] stp;
            logic [31:0] lim;
            f.changed = 1'b0;
            lim = 32'(regs.sweep_limit);
            case (cmd)
                lpfs_pkg::CMD_TICK:
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        d   = 32'(duty[c]);
                        stp = 32'(regs.step_base) * 32'(c + 1);
                        if (mode[c] != lpfs_pkg::MODE_MANUAL)
                        begin
                            f.changed = 1'b1;
                            case (mode[c])
                                lpfs_pkg::MODE_INCR:
                                begin
                                    d = d + stp;
                                    if (d > lim)
                                        d = d - lim;
                                end
                                lpfs_pkg::MODE_DECR:
                                begin
                                    if (d < stp)
                                        d = d + lim;
                                    d = (d < stp) ? 32'd0 : d - stp;
                                end
                                default:
                                begin
                                    if (up[c])
                                    begin
                                        if (d > lim)
                                        begin
                                            d     = lim;
                                            up[c] = 1'b0;
                                        end
                                        else
                                            d = d + stp;
                                    end
                                    else if (d < stp)
                                    begin
                                        d     = 32'd0;
                                        up[c] = 1'b1;
                                    end
                                    else
                                        d = d - stp;
                                end
                            endcase
                            duty[c] = (d > 32'hFFFF) ? 16'hFFFF : d[15:0];
                        end
                    end
                end
                lpfs_pkg::CMD_SET:
                begin
                    duty[ch]  = (val > regs.full_period) ? regs.full_period : val;
                    mode[ch]  = lpfs_pkg::MODE_MANUAL;
                    f.changed = 1'b1;
                end
                lpfs_pkg::CMD_MODE:
                begin
                    case (mode[ch])
                        lpfs_pkg::MODE_MANUAL: mode[ch] = lpfs_pkg::MODE_INCR;
                        lpfs_pkg::MODE_INCR:   mode[ch] = lpfs_pkg::MODE_DECR;
                        lpfs_pkg::MODE_DECR:   mode[ch] = lpfs_pkg::MODE_TOGGLE;
                        default:               mode[ch] = lpfs_pkg::MODE_MANUAL;
                    endcase
                end
                default: ;
            endcase
            for (int c = 0; c < 4; c++)
                f.duty[c] = duty[c];
            due.push_back(f);
            beats++;
        endfunction

        function void match_result(logic [3:0][15:0] got, logic got_changed);
            duty_frame_t w;
            if (due.size() == 0)
            begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
                return;
            end
            w = due.pop_front();
            checked++;
            for (int c = 0; c < 4; c++)
            begin
                if (got[c] !== w.duty[c])
                begin
                    $display("%0t: %s expected %0d actual %0d", $time, lane_name[c],
                             w.duty[c], got[c]);
                    errors++;
                end
            end
            if (got_changed !== w.changed)
            begin
                $display("%0t: changed expected %0d actual %0d", $time, w.changed, got_changed);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = lpfs_pkg::CMD_TICK;
    logic [1:0]  channel = 2'd0;
    logic [15:0] value = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] duty_zero;
    logic [15:0] duty_one;
    logic [15:0] duty_two;
    logic [15:0] duty_three;
    logic        changed;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = lpfs_pkg::REG_FULL_PERIOD;
    logic [15:0] cfg_data = 16'd0;

    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;

    duty_tracker tracker = new();

    always #1 clk = ~clk;

    led_pwm_fade_sequencer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .channel    (channel),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .duty_zero  (duty_zero),
        .duty_one   (duty_one),
        .duty_two   (duty_two),
        .duty_three (duty_three),
        .changed    (changed),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    task automatic send_beat(logic [1:0] cmd, logic [1:0] ch, logic [15:0] val);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else if (r < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        channel  <= ch;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_beat(cmd, ch, val);
    endtask

    task automatic random_beat();
        int          r;
        logic [1:0]  cmd;
        logic [15:0] val;
        r = $urandom_range(0, 99);
        if (r < 68)
            cmd = lpfs_pkg::CMD_TICK;
        else if (r < 80)
            cmd = lpfs_pkg::CMD_SET;
        else if (r < 95)
            cmd = lpfs_pkg::CMD_MODE;
        else
            cmd = CMD_UNUSED;
        if ($urandom_range(0, 1) == 1)
            val = 16'($urandom);
        else
            val = 16'($urandom_range(0, 1200));
        send_beat(cmd, 2'($urandom_range(0, 3)), val);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic program_regs(logic [15:0] fp, logic [15:0] sl, logic [15:0] sb);
        write_reg(lpfs_pkg::REG_FULL_PERIOD, fp);
        write_reg(lpfs_pkg::REG_SWEEP_LIMIT, sl);
        write_reg(lpfs_pkg::REG_STEP_BASE, sb);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side: random stalls plus two long hold-offs so the input backs up
    initial
    begin
        int stall_left;
        int taken;
        stall_left = 0;
        taken      = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                tracker.match_result({duty_three, duty_two, duty_one, duty_zero}, changed);
                taken++;
                if (taken == 400 || taken == 1000)
                    stall_left = 150;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!rx_calm && $urandom_range(0, 99) < 20)
            begin
                out_stall  <= 1'b1;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("led_pwm_fade_sequencer_core verification failed");
        $finish;
    end

    initial
    begin
        logic [15:0] fp;
        logic [15:0] sl;
        logic [15:0] sb;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: toggle sweeps, clamps, unused command, every mode
        send_beat(lpfs_pkg::CMD_TICK, 2'd0, 16'd0);
        send_beat(CMD_UNUSED, 2'd3, 16'hFFFF);
        send_beat(lpfs_pkg::CMD_SET, 2'd0, 16'd0);
        send_beat(lpfs_pkg::CMD_SET, 2'd1, 16'hFFFF);
        send_beat(lpfs_pkg::CMD_SET, 2'd2, 16'd999);
        send_beat(lpfs_pkg::CMD_SET, 2'd3, 16'd1000);
        send_beat(lpfs_pkg::CMD_TICK, 2'd1, 16'h5A5A);
        send_beat(lpfs_pkg::CMD_MODE, 2'd0, 16'd0);
        for (int i = 0; i < 2; i++)
            send_beat(lpfs_pkg::CMD_MODE, 2'd1, 16'd0);
        for (int i = 0; i < 3; i++)
            send_beat(lpfs_pkg::CMD_MODE, 2'd2, 16'd0);
        for (int i = 0; i < 4; i++)
            send_beat(lpfs_pkg::CMD_MODE, 2'd3, 16'd0);
        send_beat(lpfs_pkg::CMD_TICK, 2'd0, 16'd0);
        send_beat(lpfs_pkg::CMD_TICK, 2'd0, 16'd0);
        send_beat(lpfs_pkg::CMD_SET, 2'd0, 16'd498);
        send_beat(lpfs_pkg::CMD_MODE, 2'd0, 16'd0);
        send_beat(lpfs_pkg::CMD_TICK, 2'd0, 16'd0);

        for (int p = 1; p <= PHASES; p++)
        begin
            drain_results();
            case (p)
                1:
                begin
                    fp = 16'hFFFF;
                    sl = 16'hFFFF;
                    sb = 16'hFFFF;
                end
                2:
                begin
                    fp = 16'd0;
                    sl = 16'd0;
                    sb = 16'd0;
                end
                3:
                begin
                    fp = 16'($urandom_range(200, 5000));
                    sl = 16'($urandom_range(50, 3000));
                    sb = 16'($urandom_range(1, 30));
                end
                4:
                begin
                    fp = 16'd1;
                    sl = 16'd1;
                    sb = 16'd1;
                end
                5:
                begin
                    fp = 16'($urandom);
                    sl = 16'($urandom);
                    sb = 16'($urandom);
                end
                default:
                begin
                    fp = 16'($urandom);
                    sl = 16'($urandom_range(30000, 65535));
                    sb = 16'($urandom_range(10000, 65535));
                end
            endcase
            program_regs(fp, sl, sb);
            for (int i = 0; i < BEATS_PER_PHASE; i++)
            begin
                if (i % 60 == 0)
                begin
                    tx_calm = ($urandom_range(0, 3) == 0);
                    rx_calm <= ($urandom_range(0, 3) == 0);
                end
                // sender waits for every result mid-phase
                if (p == 3 && i == 100)
                    drain_results();
                random_beat();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("ran %0d beats of tick, set, mode and unused commands over %0d register settings",
                 tracker.beats, PHASES + 1);
        $display("compared %0d result beats, including long output stalls", tracker.checked);
        if (tracker.errors == 0 && tracker.due.size() == 0)
            $display("led_pwm_fade_sequencer_core verification clean");
        else
            $display("led_pwm_fade_sequencer_core verification failed");
        $finish;
    end

endmodule
